/* rtl/ptds_pkg.sv */
// Shared types, constants and register codes for the periodic task due scheduler.
package ptds_pkg;

	localparam int MAX_TASKS          = 4;
	localparam int DEFAULT_TASK_COUNT = 4;
	localparam int TIME_W             = 32;
	localparam int MASK_W             = MAX_TASKS;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 32;

	typedef logic [TIME_W-1:0] time_ms_t;
	typedef logic [MASK_W-1:0] task_mask_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam time_ms_t NO_TASK_WAKE_MS = time_ms_t'(1000);
	localparam time_ms_t INTERVAL_RESET  = time_ms_t'(1000);

	localparam cfg_idx_t CFG_INTERVAL_0 = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_INTERVAL_1 = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_INTERVAL_2 = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_INTERVAL_3 = cfg_idx_t'(3);
	localparam cfg_idx_t CFG_ENABLE     = cfg_idx_t'(4);

	// One candidate for the wake-time minimum.
	typedef struct packed {
		logic     have;
		logic     still;
		time_ms_t left;
	} lane_t;

endpackage

/* rtl/ptds_tick_if.sv */
// Request channel carrying one tick time.
interface ptds_tick_if import ptds_pkg::*; ();
	logic     valid;
	logic     ready;
	time_ms_t now_ms;

	modport source (output valid, output now_ms, input ready);
	modport sink (input valid, input now_ms, output ready);
endinterface

/* rtl/ptds_result_if.sv */
// Result channel carrying the due mask and the next wake time.
interface ptds_result_if import ptds_pkg::*; ();
	logic       valid;
	logic       ready;
	task_mask_t due_mask;
	time_ms_t   next_wake_ms;

	modport source (output valid, output due_mask, output next_wake_ms, input ready);
	modport sink (input valid, input due_mask, input next_wake_ms, output ready);
endinterface

/* rtl/ptds_task_unit.sv */
// Per-task due check and remaining time after the last-run update.
module ptds_task_unit import ptds_pkg::*; (
	input  time_ms_t now_ms,
	input  time_ms_t fired_at,
	input  time_ms_t interval,
	input  logic     live,
	output logic     due,
	output lane_t    lane
);
	time_ms_t elapsed;
	time_ms_t post_elapsed;

	assign elapsed      = now_ms - fired_at;
	assign due          = live && (elapsed >= interval);
	// a due task restarts at now, so its elapsed time becomes zero
	assign post_elapsed = due ? '0 : elapsed;

	assign lane.still = due && (interval == '0);
	assign lane.have  = live && !lane.still;
	assign lane.left  = interval - post_elapsed;
endmodule

/* rtl/ptds_wake_min.sv */
// Minimum tree over the task lanes giving the next wake time.
module ptds_wake_min import ptds_pkg::*; (
	input  lane_t    lanes [MAX_TASKS],
	output time_ms_t wake_ms
);
	function automatic lane_t combine(input lane_t a, input lane_t b);
		lane_t r;
		r.have  = a.have | b.have;
		r.still = a.still | b.still;
		if (a.have && (!b.have || a.left <= b.left)) begin
			r.left = a.left;
		end else begin
			r.left = b.left;
		end
		return r;
	endfunction

	lane_t lo;
	lane_t hi;
	lane_t all;

	assign lo  = combine(lanes[0], lanes[1]);
	assign hi  = combine(lanes[2], lanes[3]);
	assign all = combine(lo, hi);

	always_comb begin
		if (all.still) begin
			wake_ms = '0;
		end else if (all.have) begin
			wake_ms = all.left;
		end else begin
			wake_ms = NO_TASK_WAKE_MS;
		end
	end
endmodule

/* rtl/periodic_task_due_scheduler.sv */
// Top level of the periodic task due scheduler.
// Usage:
//   tick   : request channel, one millisecond time stamp (now_ms) per request.
//   result : one result per request, due_mask and next_wake_ms.
//   cfg_we/cfg_index/cfg_data : register writes, indexes 0..3 task intervals,
//            index 4 enable mask; write only while no request is in flight.
// A request is registered in the input register when it is accepted; the task
// checks and the wake minimum then run from that register into the result
// register, and the result is valid once it is loaded there.
// Throughput is one request per cycle unless result stalls: the single compute
// pass between the input and result registers also updates the last-run times.
// When result is stalled, the result register holds and the input register
// still takes one more request; tick.ready then drops until result moves.
// Reset clears the valid flags of both registers, sets all last-run times to zero,
// intervals to 1000 and the enable mask to zero.
module periodic_task_due_scheduler import ptds_pkg::*; #(
	parameter int TASK_COUNT = DEFAULT_TASK_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ptds_tick_if.sink             tick,
	ptds_result_if.source         result,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	time_ms_t   interval_q [MAX_TASKS];
	task_mask_t enable_q;
	time_ms_t   fired_at_q [TASK_COUNT];

	logic       valid_s1;
	time_ms_t   now_ms_s1;
	logic       valid_s2;
	task_mask_t due_s2;
	time_ms_t   wake_s2;

	logic       adv_s1;
	task_mask_t due;
	lane_t      lanes [MAX_TASKS];
	time_ms_t   wake_ms;

	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				interval_q[i] <= INTERVAL_RESET;
			end
			enable_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERVAL_0: interval_q[0] <= cfg_data[TIME_W-1:0];
				CFG_INTERVAL_1: interval_q[1] <= cfg_data[TIME_W-1:0];
				CFG_INTERVAL_2: interval_q[2] <= cfg_data[TIME_W-1:0];
				CFG_INTERVAL_3: interval_q[3] <= cfg_data[TIME_W-1:0];
				CFG_ENABLE:     enable_q      <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_task
		if (i < TASK_COUNT) begin : g_live
			ptds_task_unit u_task (
				.now_ms   (now_ms_s1),
				.fired_at (fired_at_q[i]),
				.interval (interval_q[i]),
				.live     (enable_q[i]),
				.due      (due[i]),
				.lane     (lanes[i])
			);
		end else begin : g_none
			assign due[i]   = 1'b0;
			assign lanes[i] = '0;
		end
	end

	ptds_wake_min u_wake (
		.lanes   (lanes),
		.wake_ms (wake_ms)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				fired_at_q[i] <= '0;
			end
		end else if (adv_s1) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				if (due[i]) begin
					fired_at_q[i] <= now_ms_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			now_ms_s1 <= tick.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			due_s2  <= due;
			wake_s2 <= wake_ms;
		end
	end

	assign result.valid        = valid_s2;
	assign result.due_mask     = due_s2;
	assign result.next_wake_ms = wake_s2;
endmodule
